// File: src/mat4_vec4_transform_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MAT4_VEC4_TRANSFORM_DEFINES_SVH
`define MAT4_VEC4_TRANSFORM_DEFINES_SVH

// Concurrent check, clocked on clk_i and switched off while rst_ni is low.
`define M4V4T_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that also holds while reset is applied.
`define M4V4T_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/m4v4t_pkg.sv
package m4v4t_pkg;

  // Vector shape and field widths.
  localparam int unsigned VecLen    = 4;
  localparam int unsigned CompW     = 32;
  localparam int unsigned EntryW    = 16;
  localparam int unsigned RowW      = VecLen * EntryW;
  localparam int unsigned DataW     = VecLen * CompW;

  // Widths through the lane pipeline: product, pair sum, full sum.
  localparam int unsigned ProdW     = EntryW + CompW;
  localparam int unsigned PairW     = ProdW + 1;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned FracShift = 12;
  localparam int unsigned ShW       = SumW - FracShift;

  // Configuration port.
  localparam int unsigned CfgIdxW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_ZERO  = 4'd0,
    REG_ROW_ONE   = 4'd1,
    REG_ROW_TWO   = 4'd2,
    REG_ROW_THREE = 4'd3
  } cfg_reg_e;

  // Identity matrix, one Q4.12 one on the diagonal of each row.
  localparam logic [RowW-1:0] RowReset [VecLen] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef logic signed [CompW-1:0] comp_t;

  // Stage enables that the top level hands to every lane.
  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_sum;
  } lane_ctrl_t;

endpackage

// File: src/m4v4t_lane.sv
// One matrix row times the vector: multiply, add in pairs, add, shift and saturate.
module m4v4t_lane
  import m4v4t_pkg::*;
(
  input  logic              clk_i,
  input  lane_ctrl_t        ctrl_i,
  input  logic [RowW-1:0]   row_i,
  input  comp_t             vec_i [VecLen],
  output comp_t             res_o,
  output logic              clip_o
);

  logic signed [ProdW-1:0] prod_d [VecLen];
  logic signed [ProdW-1:0] prod_q [VecLen];
  logic signed [PairW-1:0] pair_d [2];
  logic signed [PairW-1:0] pair_q [2];
  logic signed [SumW-1:0]  sum;
  logic signed [ShW-1:0]   shifted;
  comp_t                   res_d, res_q;
  logic                    clip_d, clip_q;

  // Four products of a signed Q4.12 entry with a signed Q16.16 component.
  always_comb begin
    for (int j = 0; j < VecLen; j++) begin
      prod_d[j] = ProdW'($signed(row_i[j*EntryW +: EntryW])) * ProdW'(vec_i[j]);
    end
  end

  // Pairwise sums, kept exact.
  always_comb begin
    pair_d[0] = PairW'(prod_q[0]) + PairW'(prod_q[1]);
    pair_d[1] = PairW'(prod_q[2]) + PairW'(prod_q[3]);
  end

  // Final sum, arithmetic shift by dropping the low bits, then saturation.
  always_comb begin
    sum     = SumW'(pair_q[0]) + SumW'(pair_q[1]);
    shifted = sum[SumW-1:FracShift];
    res_d   = shifted[CompW-1:0];
    clip_d  = 1'b0;
    if (!shifted[ShW-1] && (shifted[ShW-1:CompW-1] != '0)) begin
      res_d  = {1'b0, {(CompW-1){1'b1}}};
      clip_d = 1'b1;
    end else if (shifted[ShW-1] && (shifted[ShW-1:CompW-1] != '1)) begin
      res_d  = {1'b1, {(CompW-1){1'b0}}};
      clip_d = 1'b1;
    end
  end

  // Pipeline registers, each stage loaded when the top level moves it on.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.en_pair) begin
      pair_q <= pair_d;
    end
    if (ctrl_i.en_sum) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

// File: src/m4v4t_merge.sv
// Gathers the four lane results into one beat and holds it until it is taken.
module m4v4t_merge
  import m4v4t_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  comp_t             res_i [VecLen],
  input  logic [VecLen-1:0] clip_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DataW-1:0]  m_axis_tdata,   // out_x, out_y, out_z, out_w from bit 0
  output logic [0:0]        m_axis_tuser    // clipped
);

  logic             valid_d, valid_q;
  logic [DataW-1:0] data_d, data_q;
  logic             clip_d, clip_q;

  // The output register can take a new beat when empty or being drained.
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = free_o ? load_i : valid_q;
    for (int i = 0; i < VecLen; i++) begin
      data_d[i*CompW +: CompW] = res_i[i];
    end
    clip_d = |clip_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= data_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = clip_q;

endmodule

// File: src/mat4_vec4_transform.sv
// Transforms a stream of four-component signed Q16.16 vectors by a 4x4 matrix of signed
// Q4.12 entries held in four row registers (identity after reset). Each output component is
// the exact dot product of its row with the vector, shifted right arithmetically by 12 and
// saturated to 32 bits; tuser reports whether any component saturated. The block takes one
// vector per clock cycle while the output is not stalled; each result goes through the
// three-stage pipeline of each of the four row lanes (multiply, pair add, final add with
// saturation) and then the output register. Rows are written over the configuration channel,
// which is always ready; writes to an index above three are ignored, and rows should only
// be changed while no vector is in flight.
module mat4_vec4_transform
  import m4v4t_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RowW-1:0]    cfg_data_i,
  // Input vectors.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // in_x, in_y, in_z, in_w from bit 0
  // Transformed vectors.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // out_x, out_y, out_z, out_w from bit 0
  output logic [0:0]         m_axis_tuser    // clipped
);

  logic [RowW-1:0]   row_d [VecLen];
  logic [RowW-1:0]   row_q [VecLen];
  comp_t             vec [VecLen];
  lane_ctrl_t        ctrl;
  comp_t             res [VecLen];
  logic [VecLen-1:0] clip;
  logic              free;
  logic              space1, space2, space3;
  logic              v1_d, v1_q, v2_d, v2_q, v3_d, v3_q;
  logic              s_accept;

  // Row registers written by the configuration channel.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    row_d = row_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROW_ZERO:  row_d[0] = cfg_data_i;
        REG_ROW_ONE:   row_d[1] = cfg_data_i;
        REG_ROW_TWO:   row_d[2] = cfg_data_i;
        REG_ROW_THREE: row_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= RowReset;
    end else begin
      row_q <= row_d;
    end
  end

  // Unpack the input beat into its components.
  always_comb begin
    for (int j = 0; j < VecLen; j++) begin
      vec[j] = s_axis_tdata[j*CompW +: CompW];
    end
  end

  // Stage occupancy: a stage has room when empty or when its content moves on.
  assign space3        = !v3_q || free;
  assign space2        = !v2_q || space3;
  assign space1        = !v1_q || space2;
  assign s_axis_tready = space1;
  assign s_accept      = s_axis_tvalid && space1;

  always_comb begin
    ctrl.en_mul  = s_accept;
    ctrl.en_pair = v1_q && space2;
    ctrl.en_sum  = v2_q && space3;
    v1_d = space1 ? s_accept : v1_q;
    v2_d = space2 ? v1_q : v2_q;
    v3_d = space3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // One lane per matrix row.
  for (genvar i = 0; i < VecLen; i++) begin : g_lane
    m4v4t_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .row_i  (row_q[i]),
      .vec_i  (vec),
      .res_o  (res[i]),
      .clip_o (clip[i])
    );
  end

  // Merge the lanes into the output beat.
  m4v4t_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (v3_q),
    .res_i         (res),
    .clip_i        (clip),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: src/m4v4t_checker.sv
`include "mat4_vec4_transform_defines.svh"

// Port-level checks on the transform block.
module m4v4t_checker
  import m4v4t_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [DataW-1:0]   m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  logic [VecLen-1:0] at_limit;

  // A component sits at one of the two saturation limits.
  always_comb begin
    for (int i = 0; i < VecLen; i++) begin
      at_limit[i] = (m_axis_tdata[i*CompW +: CompW] == {1'b0, {(CompW-1){1'b1}}}) ||
                    (m_axis_tdata[i*CompW +: CompW] == {1'b1, {(CompW-1){1'b0}}});
    end
  end

  // A stalled output beat stays in place.
  `M4V4T_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

  // A draining output frees the whole pipeline, so the input side must be ready.
  `M4V4T_ASSERT(a_ready_flow, m_axis_tready |-> s_axis_tready, "input stalled while output drains")

  // The clip flag only comes with a component at a saturation limit.
  `M4V4T_ASSERT(a_clip_limit, m_axis_tvalid && m_axis_tuser[0] |-> (at_limit != '0), "clip flag without a saturated component")

  // No output beat is presented while reset is applied.
  `M4V4T_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind mat4_vec4_transform m4v4t_checker u_m4v4t_checker (.*);

// File: verif/mat4_vec4_transform_checker.sv
module mat4_vec4_transform_checker
  import m4v4t_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RowW-1:0]    cfg_data_i,
  // Vector input channel.
  input  logic               vec_valid_i,
  input  logic               vec_ready_i,
  input  logic [DataW-1:0]   vec_data_i,   // in_x, in_y, in_z, in_w from bit 0
  // Transformed vector channel.
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [DataW-1:0]   res_data_i,   // out_x, out_y, out_z, out_w from bit 0
  input  logic [0:0]         res_clipped_i,
  // Status for the test sequence.
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  localparam int unsigned MaxReports = 40;
  localparam longint      CompMax    = (64'sd1 <<< (CompW - 1)) - 1;
  localparam longint      CompMin    = -(64'sd1 <<< (CompW - 1));

  typedef struct packed {
    logic [DataW-1:0] comps;
    logic             clipped;
  } xform_t;

  logic [RowW-1:0] matrix [VecLen];
  xform_t          transformed_q [$];
  xform_t          want;

  // Exact dot product of each row with the vector, floored shift by the
  // fraction width of the entries, then saturation to the component range.
  function automatic xform_t transform_vec(input logic [DataW-1:0] vec);
    xform_t                   res;
    longint                   acc;
    longint                   scaled;
    logic signed [EntryW-1:0] coef;
    comp_t                    comp;
    int                       i;
    int                       j;
    res.comps   = '0;
    res.clipped = 1'b0;
    for (i = 0; i < VecLen; i++) begin
      acc = 0;
      for (j = 0; j < VecLen; j++) begin
        coef = matrix[i][EntryW*j +: EntryW];
        comp = vec[CompW*j +: CompW];
        acc += longint'(coef) * longint'(comp);
      end
      scaled = acc >>> FracShift;
      if (scaled > CompMax) begin
        scaled      = CompMax;
        res.clipped = 1'b1;
      end else if (scaled < CompMin) begin
        scaled      = CompMin;
        res.clipped = 1'b1;
      end
      res.comps[CompW*i +: CompW] = scaled[CompW-1:0];
    end
    return res;
  endfunction

  function automatic void note_failure();
    fail_count_o++;
  endfunction

  // Field-by-field comparison of one result beat with its prediction.
  task automatic compare_result(input xform_t exp_res);
    int i;
    for (i = 0; i < VecLen; i++) begin
      if (res_data_i[CompW*i +: CompW] !== exp_res.comps[CompW*i +: CompW]) begin
        if (fail_count_o < MaxReports) begin
          $display("%0t: component %0d mismatch, expected %h, got %h", $time, i,
                   exp_res.comps[CompW*i +: CompW], res_data_i[CompW*i +: CompW]);
        end
        note_failure();
      end
    end
    if (res_clipped_i[0] !== exp_res.clipped) begin
      if (fail_count_o < MaxReports) begin
        $display("%0t: clipped mismatch, expected %b, got %b", $time, exp_res.clipped,
                 res_clipped_i[0]);
      end
      note_failure();
    end
  endtask

  // Track the row registers, predict on every input beat and check every result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < VecLen; r++) begin
        matrix[r] = RowReset[r];
      end
      transformed_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_ROW_THREE) begin
        matrix[cfg_index_i[1:0]] = cfg_data_i;
      end
      if (vec_valid_i && vec_ready_i) begin
        transformed_q.push_back(transform_vec(vec_data_i));
      end
      if (res_valid_i && res_ready_i) begin
        if (transformed_q.size() == 0) begin
          if (fail_count_o < MaxReports) begin
            $display("%0t: result beat with nothing expected, expected none, got %h/%b",
                     $time, res_data_i, res_clipped_i[0]);
          end
          note_failure();
        end else begin
          want = transformed_q.pop_front();
          compare_result(want);
        end
      end
    end
    pending_o = transformed_q.size();
  end

endmodule

// File: verif/tb_mat4_vec4_transform.sv
module tb_mat4_vec4_transform;
  import m4v4t_pkg::*;

  localparam int unsigned PipeLatency   = 4;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 228;
  localparam int unsigned PressurePhase = 3;

  localparam comp_t             CompHi   = 32'sh7FFF_FFFF;
  localparam comp_t             CompLo   = 32'sh8000_0000;
  localparam comp_t             OneQ16   = 32'sh0001_0000;
  localparam logic [EntryW-1:0] EntryHi  = 16'h7FFF;
  localparam logic [EntryW-1:0] EntryLo  = 16'h8000;
  localparam logic [EntryW-1:0] EntryOne = 16'h1000;
  localparam logic [CfgIdxW-1:0] TopIdx  = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RowW-1:0]    cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DataW-1:0]   m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;

  always #4 clk_i = ~clk_i;

  mat4_vec4_transform u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mat4_vec4_transform_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .vec_valid_i   (s_axis_tvalid),
    .vec_ready_i   (s_axis_tready),
    .vec_data_i    (s_axis_tdata),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_clipped_i (m_axis_tuser),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("tb_mat4_vec4_transform failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) begin
          m_axis_tready <= 1'b1;
        end
      end else if (hold_off_req) begin
        hold_off_req  = 1'b0;
        stall_left    = HoldOffCycles;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic comp_t rand_comp();
    comp_t v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: v = comp_t'($urandom());
      // Small raw values, where the rounding of the shift shows.
      4: v = comp_t'($urandom_range(0, 32'h000F_FFFF)) - comp_t'(32'h0008_0000);
      // Ordinary coordinates within plus or minus sixteen.
      5: v = comp_t'($urandom_range(0, 32'h001F_FFFF)) - comp_t'(32'h0010_0000);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = CompHi;
          1:       v = CompLo;
          2:       v = '0;
          3:       v = -1;
          4:       v = 1;
          default: v = OneQ16;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    logic [EntryW-1:0] e;
    case ($urandom_range(0, 5))
      0, 1, 2: e = EntryW'($urandom());
      3:       e = EntryW'($urandom_range(0, 16'h1FFF) - 16'h1000);
      default: begin
        case ($urandom_range(0, 5))
          0:       e = EntryHi;
          1:       e = EntryLo;
          2:       e = '0;
          3:       e = EntryOne;
          4:       e = -EntryOne;
          default: e = 16'h0001;
        endcase
      end
    endcase
    return e;
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    logic [RowW-1:0] row;
    if ($urandom_range(0, 7) == 0) begin
      row = '0;
    end else begin
      row = {rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    end
    return row;
  endfunction

  // One vector beat, with an optional gap in front of it.
  task automatic send_vec(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, wait for every outstanding result and let the pipeline settle.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_matrix(input logic [RowW-1:0] r0, input logic [RowW-1:0] r1,
                              input logic [RowW-1:0] r2, input logic [RowW-1:0] r3);
    drain_and_settle();
    write_cfg(REG_ROW_ZERO, r0);
    write_cfg(REG_ROW_ONE, r1);
    write_cfg(REG_ROW_TWO, r2);
    write_cfg(REG_ROW_THREE, r3);
  endtask

  // Main sequence: reset, directed cases, then random phases with freshly written rows.
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned r;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_ROW_ZERO;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix from reset passes the extremes straight through.
    send_vec(CompHi, CompLo, '0, -1);
    send_vec(OneQ16, -OneQ16, 1, comp_t'(32'h8000_0001));

    // Largest positive entries: sums leave the 32-bit range both ways.
    write_matrix({4{EntryHi}}, {4{EntryHi}}, {4{EntryHi}}, {4{EntryHi}});
    send_vec(CompHi, CompHi, CompHi, CompHi);
    send_vec(CompLo, CompLo, CompLo, CompLo);
    send_vec(CompHi, CompLo, CompHi, CompLo);
    send_vec('0, '0, '0, '0);

    // Most negative entries flip the direction of saturation.
    write_matrix({4{EntryLo}}, {4{EntryLo}}, {4{EntryLo}}, {4{EntryLo}});
    send_vec(CompLo, CompLo, CompLo, CompLo);
    send_vec(CompHi, CompHi, CompHi, CompHi);

    // Rows of mixed sign, one of them all zero.
    write_matrix({EntryHi, EntryLo, EntryOne, 16'h0001}, {EntryLo, EntryHi, -EntryOne, 16'hFFFF},
                 '0, {EntryOne, EntryOne, EntryOne, EntryOne});
    send_vec(CompHi, CompLo, OneQ16, -OneQ16);
    send_vec(comp_t'(32'h1234_5678), comp_t'(32'hEDCB_A988), -1, 1);

    // Tiny diagonal entries: the shift rounds towards minus infinity.
    write_matrix(64'h1, 64'h1 << EntryW, 64'h1 << (2 * EntryW), 64'h1 << (3 * EntryW));
    send_vec(-1, comp_t'(4095), comp_t'(-4096), comp_t'(-4097));
    send_vec(1, comp_t'(4096), comp_t'(-1), comp_t'(8191));

    // A write to an unused index must leave the matrix alone.
    drain_and_settle();
    write_cfg(TopIdx, {4{EntryHi}});
    write_cfg(CfgIdxW'($urandom_range(TopIdx, REG_ROW_THREE + 1)), rand_row());
    send_vec(-1, comp_t'(-4097), CompHi, CompLo);

    // Random phases, each rewriting a random choice of rows (all of them in the first); the last runs without idling.
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_and_settle();
      if ($urandom_range(0, 2) == 0) begin
        write_cfg(CfgIdxW'($urandom_range(TopIdx, REG_ROW_THREE + 1)), rand_row());
      end
      for (r = 0; r < VecLen; r++) begin
        if (phase == 0 || $urandom_range(0, 3) != 0) begin
          write_cfg(CfgIdxW'(r), rand_row());
        end
      end
      if (phase == NumPhases - 1) begin
        idle_on = 1'b0;
      end
      if (phase == PressurePhase) begin
        hold_off_req = 1'b1;
      end
      for (n = 0; n < PhaseItems; n++) begin
        send_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end

    drain_and_settle();
    repeat (PipeLatency * 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_mat4_vec4_transform passed");
    end else begin
      $display("tb_mat4_vec4_transform failed");
    end
    $finish;
  end

endmodule

// File: mat4_vec4_transform.f
+incdir+src
src/m4v4t_pkg.sv
src/m4v4t_lane.sv
src/m4v4t_merge.sv
src/mat4_vec4_transform.sv
src/m4v4t_checker.sv
verif/mat4_vec4_transform_checker.sv
verif/tb_mat4_vec4_transform.sv
